/* rtl/core/lr_pkg.sv */
package lr_pkg;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd3
  } step_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] color;
    logic       we;
    logic       last;
  } pix_t;

endpackage

/* rtl/core/line_rasterizer.sv */
// channel   handshake            payload
// request   in_valid / in_ready  req_type, start_x, start_y, end_x, end_y, line_color
// pixel     out_valid / out_ready pixel_x, pixel_y, pixel_color, write_enable, last_pixel
//
// one request is taken per cycle while in_ready is high; a busy tick yields its pixel
// a start loads the line state in the cycle it is taken and yields no pixel
// pixels leave through an output register backed by one skid entry; in_ready drops
// only while the skid entry is full
// rst is synchronous and clears the line state and both output entries
module line_rasterizer #(
  parameter int SCREEN_HEIGHT = 240,
  parameter int SCREEN_WIDTH  = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic        [7:0] line_color,
  output logic              out_valid,
  input  logic              out_ready,
  output logic        [7:0] pixel_x,
  output logic        [7:0] pixel_y,
  output logic        [7:0] pixel_color,
  output logic              write_enable,
  output logic              last_pixel
);

  localparam logic [8:0] HEIGHT_LIM = 9'(SCREEN_HEIGHT);
  localparam logic [8:0] WIDTH_LIM  = 9'(SCREEN_WIDTH);

  logic              busy;
  logic [15:0]       cur_x;
  logic [15:0]       cur_y;
  logic [15:0]       adx;
  logic [15:0]       ady;
  lr_pkg::step_t     sgn_x;
  lr_pkg::step_t     sgn_y;
  logic [15:0]       major_dist;
  logic [16:0]       err_x;
  logic [16:0]       err_y;
  logic [16:0]       done_cnt;
  logic [7:0]        color;

  lr_pkg::pix_t      out_reg;
  lr_pkg::pix_t      skid_reg;
  logic              skid_valid;

  logic              in_fire;
  logic              is_start;
  logic              res_valid;
  lr_pkg::pix_t      res;

  // start path
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [15:0]        adx_next;
  logic [15:0]        ady_next;
  lr_pkg::step_t      sgn_x_next;
  lr_pkg::step_t      sgn_y_next;

  // tick path
  logic [16:0]        sum_x;
  logic [16:0]        sum_y;
  logic               stp_x;
  logic               stp_y;
  logic [16:0]        err_x_next;
  logic [16:0]        err_y_next;
  logic [15:0]        cur_x_next;
  logic [15:0]        cur_y_next;
  logic               last;

  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign is_start  = (req_type == lr_pkg::REQ_START);
  assign res_valid = in_fire && !is_start && busy;

  always_comb begin
    dx = 17'(end_x) - 17'(start_x);
    dy = 17'(end_y) - 17'(start_y);
    if (dx > 17'sd0) begin
      sgn_x_next = lr_pkg::STEP_UP;
      adx_next   = dx[15:0];
    end else if (dx == 17'sd0) begin
      sgn_x_next = lr_pkg::STEP_NONE;
      adx_next   = '0;
    end else begin
      sgn_x_next = lr_pkg::STEP_DOWN;
      adx_next   = 16'(-dx);
    end
    if (dy > 17'sd0) begin
      sgn_y_next = lr_pkg::STEP_UP;
      ady_next   = dy[15:0];
    end else if (dy == 17'sd0) begin
      sgn_y_next = lr_pkg::STEP_NONE;
      ady_next   = '0;
    end else begin
      sgn_y_next = lr_pkg::STEP_DOWN;
      ady_next   = 16'(-dy);
    end
  end

  always_comb begin
    sum_x      = err_x + {1'b0, adx};
    sum_y      = err_y + {1'b0, ady};
    stp_x      = sum_x > {1'b0, major_dist};
    stp_y      = sum_y > {1'b0, major_dist};
    err_x_next = stp_x ? sum_x - {1'b0, major_dist} : sum_x;
    err_y_next = stp_y ? sum_y - {1'b0, major_dist} : sum_y;
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (stp_x) begin
      unique case (sgn_x)
        lr_pkg::STEP_UP:   cur_x_next = cur_x + 16'd1;
        lr_pkg::STEP_DOWN: cur_x_next = cur_x - 16'd1;
        default:           cur_x_next = cur_x;
      endcase
    end
    if (stp_y) begin
      unique case (sgn_y)
        lr_pkg::STEP_UP:   cur_y_next = cur_y + 16'd1;
        lr_pkg::STEP_DOWN: cur_y_next = cur_y - 16'd1;
        default:           cur_y_next = cur_y;
      endcase
    end
    last      = (done_cnt == ({1'b0, major_dist} + 17'd1));
    res.x     = cur_x[7:0];
    res.y     = cur_y[7:0];
    res.color = color;
    res.we    = ({1'b0, cur_y[7:0]} < HEIGHT_LIM) && ({1'b0, cur_x[7:0]} < WIDTH_LIM);
    res.last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      cur_x      <= '0;
      cur_y      <= '0;
      adx        <= '0;
      ady        <= '0;
      sgn_x      <= lr_pkg::STEP_NONE;
      sgn_y      <= lr_pkg::STEP_NONE;
      major_dist <= '0;
      err_x      <= '0;
      err_y      <= '0;
      done_cnt   <= '0;
      color      <= '0;
    end else if (in_fire && is_start) begin
      busy       <= 1'b1;
      cur_x      <= start_x;
      cur_y      <= start_y;
      adx        <= adx_next;
      ady        <= ady_next;
      sgn_x      <= sgn_x_next;
      sgn_y      <= sgn_y_next;
      major_dist <= (adx_next > ady_next) ? adx_next : ady_next;
      err_x      <= '0;
      err_y      <= '0;
      done_cnt   <= '0;
      color      <= line_color;
    end else if (res_valid) begin
      cur_x    <= cur_x_next;
      cur_y    <= cur_y_next;
      err_x    <= err_x_next;
      err_y    <= err_y_next;
      done_cnt <= done_cnt + 17'd1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (res_valid) begin
        out_reg <= res;
      end
    end else if (res_valid) begin
      skid_reg <= res;
    end
  end

  assign pixel_x      = out_reg.x;
  assign pixel_y      = out_reg.y;
  assign pixel_color  = out_reg.color;
  assign write_enable = out_reg.we;
  assign last_pixel   = out_reg.last;

endmodule

/* verif/line_rasterizer_tb.sv */
`timescale 1ns / 100ps

module line_rasterizer_tb;

  localparam int SCREEN_H    = 240;
  localparam int SCREEN_W    = 256;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_LIMIT = 60;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic req_type;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic [7:0] line_color;
  logic out_valid;
  logic out_ready;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] pixel_color;
  logic write_enable;
  logic last_pixel;

  // line state of the predictor
  bit            drawing;
  logic [15:0]   pos_x, pos_y;
  logic [15:0]   run_x, run_y, span;
  lr_pkg::step_t dir_x, dir_y;
  logic [16:0]   acc_x, acc_y, drawn;
  logic [7:0]    ink;

  lr_pkg::pix_t pending_pixels[$];
  int   fail_count;
  int   sent_items;
  int   cycles;
  int   idle_pct;
  int   stall_pct;
  bit   drained_once;

  line_rasterizer #(
    .SCREEN_HEIGHT(SCREEN_H),
    .SCREEN_WIDTH (SCREEN_W)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .line_color  (line_color),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .write_enable(write_enable),
    .last_pixel  (last_pixel)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int axis_len(input logic signed [15:0] a, input logic signed [15:0] b);
    int d;
    d = int'(b) - int'(a);
    return (d < 0) ? -d : d;
  endfunction

  function automatic void set_axis(input logic signed [15:0] a, input logic signed [15:0] b,
                                   output logic [15:0] mag, output lr_pkg::step_t dir);
    int d;
    d = int'(b) - int'(a);
    if (d > 0) begin
      dir = lr_pkg::STEP_UP;
      mag = d[15:0];
    end else if (d == 0) begin
      dir = lr_pkg::STEP_NONE;
      mag = '0;
    end else begin
      dir = lr_pkg::STEP_DOWN;
      mag = 16'(-d);
    end
  endfunction

  function automatic logic [15:0] advance(input logic [15:0] c, input lr_pkg::step_t dir);
    case (dir)
      lr_pkg::STEP_UP:   return c + 16'd1;
      lr_pkg::STEP_DOWN: return c - 16'd1;
      default:           return c;
    endcase
  endfunction

  function automatic void predict_request();
    lr_pkg::pix_t px;
    if (req_type == lr_pkg::REQ_START) begin
      set_axis(start_x, end_x, run_x, dir_x);
      set_axis(start_y, end_y, run_y, dir_y);
      span    = (run_x > run_y) ? run_x : run_y;
      pos_x   = start_x;
      pos_y   = start_y;
      ink     = line_color;
      acc_x   = '0;
      acc_y   = '0;
      drawn   = '0;
      drawing = 1'b1;
    end else if (drawing) begin
      px.x     = pos_x[7:0];
      px.y     = pos_y[7:0];
      px.color = ink;
      px.we    = (int'(px.y) < SCREEN_H) && (int'(px.x) < SCREEN_W);
      px.last  = (drawn == {1'b0, span} + 17'd1);
      pending_pixels.push_back(px);
      acc_x = acc_x + {1'b0, run_x};
      acc_y = acc_y + {1'b0, run_y};
      if (acc_x > {1'b0, span}) begin
        acc_x = acc_x - {1'b0, span};
        pos_x = advance(pos_x, dir_x);
      end
      if (acc_y > {1'b0, span}) begin
        acc_y = acc_y - {1'b0, span};
        pos_y = advance(pos_y, dir_y);
      end
      drawn = drawn + 17'd1;
      if (px.last) drawing = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < PRINT_LIMIT)
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    fail_count++;
  endtask

  task automatic check_pixel();
    lr_pkg::pix_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch("pixel with none pending, x", int'(pixel_x), -1);
      return;
    end
    want = pending_pixels.pop_front();
    if (pixel_x !== want.x) report_mismatch("pixel_x", int'(pixel_x), int'(want.x));
    if (pixel_y !== want.y) report_mismatch("pixel_y", int'(pixel_y), int'(want.y));
    if (pixel_color !== want.color)
      report_mismatch("pixel_color", int'(pixel_color), int'(want.color));
    if (write_enable !== want.we)
      report_mismatch("write_enable", int'(write_enable), int'(want.we));
    if (last_pixel !== want.last)
      report_mismatch("last_pixel", int'(last_pixel), int'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_pixel();
      if (in_valid && in_ready) predict_request();
    end
  end

  task automatic send_req(input lr_pkg::req_t kind, input logic [15:0] sx,
                          input logic [15:0] sy, input logic [15:0] ex,
                          input logic [15:0] ey, input logic [7:0] col);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    start_x    <= sx;
    start_y    <= sy;
    end_x      <= ex;
    end_y      <= ey;
    line_color <= col;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic send_tick();
    send_req(lr_pkg::REQ_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             8'($urandom));
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_tick();
    send_tick();
  endtask

  task automatic test_equal_endpoints();
    send_req(lr_pkg::REQ_START, 16'd5, 16'd5, 16'd5, 16'd5, 8'hFF);
    repeat (2) send_tick();
  endtask

  // crosses x = 0 and the bottom of the screen
  task automatic test_offscreen_wrap();
    send_req(lr_pkg::REQ_START, -16'sd2, 16'd238, 16'd1, 16'd242, 8'h00);
    repeat (6) send_tick();
  endtask

  task automatic test_restart_while_busy();
    send_req(lr_pkg::REQ_START, 16'd0, 16'd0, 16'd100, 16'd50, 8'hA5);
    repeat (2) send_tick();
    send_req(lr_pkg::REQ_START, -16'sd1, -16'sd1, 16'd1, 16'd0, 8'h5A);
    repeat (4) send_tick();
  endtask

  task automatic test_extreme_endpoints();
    send_req(lr_pkg::REQ_START, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 8'hC3);
    send_tick();
    send_req(lr_pkg::REQ_START, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'h3C);
    repeat (2) send_tick();
  endtask

  task automatic test_random(input int n_items, input int idle, input int stall);
    int first;
    int kind;
    int reach;
    int span_len;
    int ticks;
    logic signed [15:0] sx, sy, ex, ey;
    idle_pct  = idle;
    stall_pct = stall;
    first     = sent_items;
    while (sent_items - first < n_items) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        sx = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(300)) - 20);
        sy = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(280)) - 20);
        reach = ($urandom_range(3) == 0) ? 40 : 8;
        ex = 16'(int'(sx) + int'($urandom_range(2 * reach)) - reach);
        ey = 16'(int'(sy) + int'($urandom_range(2 * reach)) - reach);
        span_len = axis_len(sx, ex);
        if (axis_len(sy, ey) > span_len) span_len = axis_len(sy, ey);
        ticks = (span_len > 60) ? $urandom_range(1, 5) : span_len + 2;
        if ($urandom_range(9) == 0) ticks = $urandom_range(ticks - 1);
        send_req(lr_pkg::REQ_START, sx, sy, ex, ey, 8'($urandom));
        for (int i = 0; i < ticks; i++) begin
          if (i == ticks / 2 && (!drained_once || $urandom_range(19) == 0)) begin
            pause_until_drained();
            drained_once = 1'b1;
          end
          send_tick();
        end
        if ($urandom_range(9) == 0) send_tick();
      end else if (kind < 90) begin
        send_tick();
      end else begin
        send_req(lr_pkg::REQ_START, 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 8'($urandom));
        repeat ($urandom_range(3)) send_tick();
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= lr_pkg::REQ_START;
    start_x    <= '0;
    start_y    <= '0;
    end_x      <= '0;
    end_y      <= '0;
    line_color <= '0;
    out_ready  <= 1'b0;
    cycles     = 0;
    fail_count = 0;
    sent_items = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    drawing    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_tick();
    test_equal_endpoints();
    test_offscreen_wrap();
    test_restart_while_busy();
    test_extreme_endpoints();
    test_idle_tick();

    test_random(175, 0, 0);
    test_random(175, 66, 0);
    test_random(175, 0, 66);
    test_random(175, 8, 8);

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/lr_pkg.sv
rtl/core/line_rasterizer.sv
verif/line_rasterizer_tb.sv
